// File: design/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int ADDR_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 11;
   localparam int BSIZE_W  = 21;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS   = 2'd2;

   // Register reset values
   localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
   localparam logic [BSIZE_W-1:0] RST_BLOCK_BYTES  = 21'd64;
   localparam logic [CNT_W-1:0]   RST_NUM_BLOCKS   = 11'd0;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_INIT,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] address;
   } queue_entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base_address;
      logic [BSIZE_W-1:0] block_bytes;
      logic [CNT_W-1:0]   num_blocks;
   } csr_type;

   function automatic op_type decode_cmd(input logic [CMD_W-1:0] cmd);
      op_type op;
      case (cmd)
         CMD_ALLOC: op = OP_ALLOC;
         CMD_FREE:  op = OP_FREE;
         CMD_INIT:  op = OP_INIT;
         default:   op = OP_NOP;
      endcase
      return op;
   endfunction

endpackage

// File: design/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: registers, front end, back end.
`timescale 1ns / 1ps

// Hands out equal-size blocks from a pool at base_address; each block is a
// header followed by block_bytes, and callers get the address past the header.
// Request beat (req_valid/req_ready): req_cmd alloc, free, init or no-op, and
// req_address for free. Each request gives exactly one response beat
// (rsp_valid/rsp_ready): block address, status and free block count.
// Registers are written through csr_write_enable/csr_index/csr_write_data
// with no wait; base and count take effect at the next init command.
// Requests enter a two-entry queue; the back end takes one per cycle while
// the response register is empty or being drained and no stack read is
// pending. An alloc served from the freed-block stack also waits for the
// registered stack RAM read; other requests go from the queue straight to
// the response register. A stalled receiver holds the response register;
// the queue then fills and req_ready drops. Reset empties the pool (alloc
// reports empty, free reports refused) and loads register defaults; no
// clearing pass is needed since the stack is read only below its top.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS   = 1024,
   parameter int HEADER_BYTES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [fbpa_pkg::CMD_W-1:0]            req_cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]           req_address,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [fbpa_pkg::ADDR_W-1:0]           rsp_block_address,
   output logic [fbpa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [fbpa_pkg::CNT_W-1:0]            rsp_free_count,
   input  logic                                  csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   fbpa_pkg::csr_type         csr_ff, csr_in;
   logic                      q_valid;
   logic                      q_pop;
   fbpa_pkg::queue_entry_type q_entry;

   // Register file; writes to an unused index are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fbpa_pkg::CSR_BASE_ADDRESS: csr_in.base_address = csr_write_data;
            fbpa_pkg::CSR_BLOCK_BYTES:
               csr_in.block_bytes = csr_write_data[fbpa_pkg::BSIZE_W-1:0];
            fbpa_pkg::CSR_NUM_BLOCKS:
               csr_in.num_blocks = csr_write_data[fbpa_pkg::CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.base_address <= fbpa_pkg::RST_BASE_ADDRESS;
         csr_ff.block_bytes  <= fbpa_pkg::RST_BLOCK_BYTES;
         csr_ff.num_blocks   <= fbpa_pkg::RST_NUM_BLOCKS;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Front: decode and queue request beats
   fbpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_address (req_address),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   // Back: execute against the stack and counters, drive the response beat
   fbpa_back #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

// File: design/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fbpa_front.sv
// Request front end: decodes commands and buffers them in a two-entry queue.
`timescale 1ns / 1ps

module fbpa_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fbpa_pkg::CMD_W-1:0]         req_cmd,
   input  logic [fbpa_pkg::ADDR_W-1:0]        req_address,
   output logic                               q_valid,
   output fbpa_pkg::queue_entry_type          q_entry,
   input  logic                               q_pop
);

   fbpa_pkg::queue_entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff].op      <= fbpa_pkg::decode_cmd(req_cmd);
         entry_ff[wr_ptr_ff].address <= req_address;
      end
   end

endmodule

// File: design/fbpa_back.sv
// Allocator back end: free stack, pool counters and the response register.
`timescale 1ns / 1ps

module fbpa_back #(
   parameter int MAX_BLOCKS   = 1024,
   parameter int HEADER_BYTES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fbpa_pkg::csr_type                  csr,
   input  logic                               q_valid,
   input  fbpa_pkg::queue_entry_type          q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fbpa_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [fbpa_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fbpa_pkg::CNT_W-1:0]         rsp_free_count
);

   // Counts never exceed the 11-bit block count, so the stack needs no more
   // entries than that.
   localparam int STACK_DEPTH = (MAX_BLOCKS < 2048) ? MAX_BLOCKS : 2048;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [31:0] MAX_W = 32'(MAX_BLOCKS);
   localparam logic [fbpa_pkg::ADDR_W-1:0] HDR_W = 32'(HEADER_BYTES);
   localparam int CW = fbpa_pkg::CNT_W;

   typedef enum logic {
      S_RUN,
      S_POP
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] pool_ff, pool_in;
   logic [fbpa_pkg::ADDR_W-1:0] next_addr_ff, next_addr_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                 rsp_count_ff, rsp_count_in;

   logic          start;
   logic          rd_en;
   logic          wr_en;
   logic [CW-1:0] depth_dec;
   logic [CW-1:0] capped;
   logic [fbpa_pkg::ADDR_W-1:0] stride;
   logic [fbpa_pkg::ADDR_W-1:0] rd_data;

   assign start     = (state_ff == S_RUN) && q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = start;
   assign depth_dec = depth_ff - CW'(1);
   assign stride    = HDR_W + {11'd0, csr.block_bytes};
   assign capped    = ({21'd0, csr.num_blocks} > MAX_W) ? MAX_W[CW-1:0] : csr.num_blocks;

   fbpa_ram #(
      .WIDTH (fbpa_pkg::ADDR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (q_entry.address),
      .rd_en   (rd_en),
      .rd_addr (depth_dec[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      pool_in       = pool_ff;
      next_addr_in  = next_addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == S_POP) begin
         rsp_addr_in  = rd_data;
         rsp_valid_in = 1'b1;
         state_in     = S_RUN;
      end else if (start) begin
         rsp_addr_in   = '0;
         rsp_status_in = fbpa_pkg::STATUS_OK;
         rsp_valid_in  = 1'b1;
         case (q_entry.op)
            fbpa_pkg::OP_INIT: begin
               pool_in      = capped;
               depth_in     = '0;
               used_in      = '0;
               free_in      = capped;
               next_addr_in = csr.base_address + HDR_W;
            end
            fbpa_pkg::OP_ALLOC: begin
               if (free_ff == '0) begin
                  rsp_status_in = fbpa_pkg::STATUS_EMPTY;
               end else if (depth_ff != '0) begin
                  // Freed block on the stack: address arrives next cycle
                  rd_en        = 1'b1;
                  depth_in     = depth_dec;
                  free_in      = free_ff - CW'(1);
                  rsp_valid_in = 1'b0;
                  state_in     = S_POP;
               end else if (used_ff < pool_ff) begin
                  rsp_addr_in  = next_addr_ff;
                  next_addr_in = next_addr_ff + stride;
                  used_in      = used_ff + CW'(1);
                  free_in      = free_ff - CW'(1);
               end else begin
                  rsp_status_in = fbpa_pkg::STATUS_EMPTY;
               end
            end
            fbpa_pkg::OP_FREE: begin
               if ((free_ff >= pool_ff) || ({21'd0, depth_ff} >= MAX_W)) begin
                  rsp_status_in = fbpa_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  depth_in = depth_ff + CW'(1);
                  free_in  = free_ff + CW'(1);
               end
            end
            default: begin
            end
         endcase
         rsp_count_in = free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         depth_ff     <= '0;
         used_ff      <= '0;
         free_ff      <= '0;
         pool_ff      <= '0;
         next_addr_ff <= HDR_W;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         pool_ff      <= pool_in;
         next_addr_ff <= next_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_free_count    = rsp_count_ff;

endmodule
